// ===== src/file_transfer_receiver_fsm_core_assert.svh =====
// assertion macros shared by the receiver rtl
// each macro expects clk and rst_n in scope
`ifndef FILE_TRANSFER_RECEIVER_FSM_CORE_ASSERT_SVH
`define FILE_TRANSFER_RECEIVER_FSM_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FTR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ftr_pkg.sv =====
`timescale 1ns / 1ps

package ftr_pkg;

    // field widths
    localparam int SEQ_W     = 6;
    localparam int TRY_W     = 8;
    localparam int CMD_W     = 3;
    localparam int PHASE_W   = 3;
    localparam int TDATA_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map (index taken from paddr above the byte offset)
    localparam logic REG_MAX_TRIES = 1'b0;
    localparam logic [TRY_W-1:0] MAX_TRIES_RESET = 8'd5;
    localparam logic [TRY_W-1:0] TRY_SAT = 8'hFF;

    // packet events
    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 3'd0,
        CMD_SINIT  = 3'd1,
        CMD_FHDR   = 3'd2,
        CMD_DATA   = 3'd3,
        CMD_EOF    = 3'd4,
        CMD_BREAK  = 3'd5,
        CMD_NONE   = 3'd6,
        CMD_OTHER  = 3'd7
    } ftr_cmd_t;

    // protocol phases
    typedef enum logic [PHASE_W-1:0] {
        PH_INIT  = 3'd0,
        PH_FILE  = 3'd1,
        PH_DATA  = 3'd2,
        PH_DONE  = 3'd3,
        PH_ABORT = 3'd4
    } ftr_phase_t;

    // protocol state carried from one event to the next
    typedef struct packed {
        ftr_phase_t        phase;
        logic [SEQ_W-1:0]  expected_seq;
        logic [TRY_W-1:0]  try_count;
        logic [TRY_W-1:0]  old_try_count;
    } ftr_state_t;

    // one received packet event
    typedef struct packed {
        logic              file_open_ok;
        logic [SEQ_W-1:0]  seq_number;
        ftr_cmd_t          command;
    } ftr_event_t;

    // decision for one event
    typedef struct packed {
        ftr_phase_t        proto_state;
        logic              close_file;
        logic              open_file;
        logic              write_data;
        logic              ack_with_params;
        logic [SEQ_W-1:0]  ack_seq;
        logic              send_ack;
    } ftr_result_t;

    // saturating retry counter increment
    function automatic logic [TRY_W-1:0] sat_inc(input logic [TRY_W-1:0] cnt);
        sat_inc = (cnt == TRY_SAT) ? cnt : cnt + 8'd1;
    endfunction

endpackage

// ===== src/ftr_apb_regs.sv =====
`timescale 1ns / 1ps

module ftr_apb_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ftr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ftr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ftr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [ftr_pkg::TRY_W-1:0]        max_tries
);

    logic                        wr_en;
    logic                        sel_max_tries;
    logic [ftr_pkg::TRY_W-1:0]   max_tries_reg;
    logic [ftr_pkg::TRY_W-1:0]   max_tries_next;

    // register decode, word index above the byte offset
    assign sel_max_tries = (paddr[2] == ftr_pkg::REG_MAX_TRIES);
    assign wr_en         = psel && penable && pwrite;

    always_comb
    begin
        max_tries_next = max_tries_reg;
        if (wr_en && sel_max_tries)
        begin
            max_tries_next = pwdata[ftr_pkg::TRY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tries_reg <= ftr_pkg::MAX_TRIES_RESET;
        end
        else
        begin
            max_tries_reg <= max_tries_next;
        end
    end

    // read back, unmapped words read as zero
    assign prdata    = sel_max_tries ?
                       {{(ftr_pkg::APB_DATA_W-ftr_pkg::TRY_W){1'b0}}, max_tries_reg} :
                       {ftr_pkg::APB_DATA_W{1'b0}};
    assign pready    = 1'b1;
    assign max_tries = max_tries_reg;

endmodule

// ===== src/ftr_decide.sv =====
`timescale 1ns / 1ps

module ftr_decide
(
    input  ftr_pkg::ftr_state_t          cur,
    input  ftr_pkg::ftr_event_t          ev,
    input  logic [ftr_pkg::TRY_W-1:0]    max_tries,
    output ftr_pkg::ftr_state_t          nxt,
    output ftr_pkg::ftr_result_t         res
);

    logic                        try_over;
    logic                        old_over;
    logic [ftr_pkg::TRY_W-1:0]   try_inc;
    logic [ftr_pkg::TRY_W-1:0]   old_inc;
    logic [ftr_pkg::SEQ_W-1:0]   prev_seq;
    logic [ftr_pkg::SEQ_W-1:0]   exp_inc;
    logic                        seq_is_exp;
    logic                        seq_is_prev;

    // retry checks use the count before its increment
    assign try_over    = cur.try_count > max_tries;
    assign old_over    = cur.old_try_count > max_tries;
    assign try_inc     = ftr_pkg::sat_inc(cur.try_count);
    assign old_inc     = ftr_pkg::sat_inc(cur.old_try_count);
    // sequence numbers wrap modulo 64
    assign prev_seq    = cur.expected_seq - 6'd1;
    assign exp_inc     = cur.expected_seq + 6'd1;
    assign seq_is_exp  = ev.seq_number == cur.expected_seq;
    assign seq_is_prev = ev.seq_number == prev_seq;

    // next state and decision for one packet event
    always_comb
    begin
        nxt = cur;
        res = '0;
        res.proto_state = cur.phase;

        if (ev.command == ftr_pkg::CMD_START)
        begin
            nxt.phase        = ftr_pkg::PH_INIT;
            nxt.expected_seq = '0;
            nxt.try_count    = '0;
        end
        else if (cur.phase inside {ftr_pkg::PH_INIT, ftr_pkg::PH_FILE, ftr_pkg::PH_DATA})
        begin
            nxt.try_count = try_inc;
            if (try_over)
            begin
                nxt.phase = ftr_pkg::PH_ABORT;
            end
            else if (ev.command == ftr_pkg::CMD_NONE)
            begin
                nxt.phase = cur.phase;
            end
            else
            begin
                case (cur.phase)
                    // waiting for send-init
                    ftr_pkg::PH_INIT:
                    begin
                        if (ev.command == ftr_pkg::CMD_SINIT)
                        begin
                            res.send_ack        = 1'b1;
                            res.ack_seq         = cur.expected_seq;
                            res.ack_with_params = 1'b1;
                            nxt.old_try_count   = try_inc;
                            nxt.try_count       = '0;
                            nxt.expected_seq    = exp_inc;
                            nxt.phase           = ftr_pkg::PH_FILE;
                        end
                        else
                        begin
                            nxt.phase = ftr_pkg::PH_ABORT;
                        end
                    end

                    // waiting for a file header or break
                    ftr_pkg::PH_FILE:
                    begin
                        case (ev.command)
                            ftr_pkg::CMD_SINIT, ftr_pkg::CMD_EOF:
                            begin
                                nxt.old_try_count = old_inc;
                                if (old_over || !seq_is_prev)
                                begin
                                    nxt.phase = ftr_pkg::PH_ABORT;
                                end
                                else
                                begin
                                    res.send_ack        = 1'b1;
                                    res.ack_seq         = ev.seq_number;
                                    res.ack_with_params = (ev.command == ftr_pkg::CMD_SINIT);
                                    nxt.try_count       = '0;
                                end
                            end
                            ftr_pkg::CMD_FHDR:
                            begin
                                if (!seq_is_exp || !ev.file_open_ok)
                                begin
                                    nxt.phase = ftr_pkg::PH_ABORT;
                                end
                                else
                                begin
                                    res.send_ack      = 1'b1;
                                    res.ack_seq       = cur.expected_seq;
                                    res.open_file     = 1'b1;
                                    nxt.old_try_count = try_inc;
                                    nxt.try_count     = '0;
                                    nxt.expected_seq  = exp_inc;
                                    nxt.phase         = ftr_pkg::PH_DATA;
                                end
                            end
                            ftr_pkg::CMD_BREAK:
                            begin
                                if (!seq_is_exp)
                                begin
                                    nxt.phase = ftr_pkg::PH_ABORT;
                                end
                                else
                                begin
                                    res.send_ack = 1'b1;
                                    res.ack_seq  = cur.expected_seq;
                                    nxt.phase    = ftr_pkg::PH_DONE;
                                end
                            end
                            default:
                            begin
                                nxt.phase = ftr_pkg::PH_ABORT;
                            end
                        endcase
                    end

                    // receiving file data
                    default:
                    begin
                        case (ev.command)
                            ftr_pkg::CMD_DATA:
                            begin
                                if (!seq_is_exp)
                                begin
                                    nxt.old_try_count = old_inc;
                                    if (old_over || !seq_is_prev)
                                    begin
                                        nxt.phase = ftr_pkg::PH_ABORT;
                                    end
                                    else
                                    begin
                                        res.send_ack        = 1'b1;
                                        res.ack_seq         = ev.seq_number;
                                        res.ack_with_params = 1'b1;
                                        nxt.try_count       = '0;
                                    end
                                end
                                else
                                begin
                                    res.write_data    = 1'b1;
                                    res.send_ack      = 1'b1;
                                    res.ack_seq       = cur.expected_seq;
                                    nxt.old_try_count = try_inc;
                                    nxt.try_count     = '0;
                                    nxt.expected_seq  = exp_inc;
                                end
                            end
                            ftr_pkg::CMD_FHDR:
                            begin
                                nxt.old_try_count = old_inc;
                                if (old_over || !seq_is_prev)
                                begin
                                    nxt.phase = ftr_pkg::PH_ABORT;
                                end
                                else
                                begin
                                    res.send_ack  = 1'b1;
                                    res.ack_seq   = ev.seq_number;
                                    nxt.try_count = '0;
                                end
                            end
                            ftr_pkg::CMD_EOF:
                            begin
                                if (!seq_is_exp)
                                begin
                                    nxt.phase = ftr_pkg::PH_ABORT;
                                end
                                else
                                begin
                                    res.send_ack     = 1'b1;
                                    res.ack_seq      = cur.expected_seq;
                                    res.close_file   = 1'b1;
                                    nxt.expected_seq = exp_inc;
                                    nxt.phase        = ftr_pkg::PH_FILE;
                                end
                            end
                            default:
                            begin
                                nxt.phase = ftr_pkg::PH_ABORT;
                            end
                        endcase
                    end
                endcase
            end
        end

        res.proto_state = nxt.phase;
    end

endmodule

// ===== src/file_transfer_receiver_fsm_core.sv =====
`timescale 1ns / 1ps

// Receive-side state machine of a packet file-transfer protocol. Each stream
// transaction on the s_ side is one packet event (start, packet type with its
// sequence number, or timeout); for each one exactly one decision comes out
// on the m_ side: whether to acknowledge, the acknowledgement sequence number,
// whether parameters go with it, the write/open/close flags and the new
// protocol phase. One event is taken per clock cycle while decisions are accepted;
// an event passes an input register and then a result register before its decision
// is offered, and back-pressure on the m_ side holds it in the input register.
// The phase, expected sequence number and retry counters are updated by the decision
// logic as an event moves on from the input register into the result register.
// The retry limit max_tries sits at byte address 0 of the register port and
// should only be written while no event is in flight.

`include "file_transfer_receiver_fsm_core_assert.svh"

module file_transfer_receiver_fsm_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    // event stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] command, [8:3] seq_number, [9] file_open_ok, [15:10] zero
    input  logic [ftr_pkg::TDATA_W-1:0]      s_tdata,
    // decision stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] send_ack, [6:1] ack_seq, [7] ack_with_params, [8] write_data,
    // [9] open_file, [10] close_file, [13:11] proto_state, [15:14] zero
    output logic [ftr_pkg::TDATA_W-1:0]      m_tdata,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ftr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ftr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ftr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [ftr_pkg::TRY_W-1:0]   max_tries;
    logic                        in_take;
    logic                        advance;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    ftr_pkg::ftr_event_t         in_event_reg;
    ftr_pkg::ftr_event_t         in_event_next;

    ftr_pkg::ftr_state_t         state_reg;
    ftr_pkg::ftr_state_t         state_next;
    ftr_pkg::ftr_state_t         state_calc;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    ftr_pkg::ftr_result_t        out_res_reg;
    ftr_pkg::ftr_result_t        out_res_next;
    ftr_pkg::ftr_result_t        res_calc;

    // configuration registers
    ftr_apb_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_tries (max_tries)
    );

    // event decision logic
    ftr_decide u_decide
    (
        .cur       (state_reg),
        .ev        (in_event_reg),
        .max_tries (max_tries),
        .nxt       (state_calc),
        .res       (res_calc)
    );

    // handshake: an event moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_event_next = in_event_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_event_next = ftr_pkg::ftr_event_t'(s_tdata[9:0]);
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // protocol state and result register
    always_comb
    begin
        state_next     = state_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            state_next     = state_calc;
            out_res_next   = res_calc;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: ftr_pkg::PH_INIT, expected_seq: '0,
                               try_count: '0, old_try_count: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_event_reg <= in_event_next;
        out_res_reg  <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    // checks on the decision path
    `FTR_ASSERT_NEXT(a_start_clears, advance && in_event_reg.command == ftr_pkg::CMD_START, state_reg.phase == ftr_pkg::PH_INIT && state_reg.expected_seq == '0 && state_reg.try_count == '0, "start did not clear the protocol state")
    `FTR_ASSERT_NEXT(a_final_phase_held, advance && in_event_reg.command != ftr_pkg::CMD_START && (state_reg.phase == ftr_pkg::PH_DONE || state_reg.phase == ftr_pkg::PH_ABORT), state_reg == $past(state_reg) && !out_res_reg.send_ack, "final phase left without a start")
    `FTR_ASSERT_NEXT(a_result_tracks_phase, advance, out_valid_reg && out_res_reg.proto_state == state_reg.phase, "reported phase differs from the state register")
    `FTR_ASSERT_SAME(a_no_ack_no_seq, out_valid_reg && !out_res_reg.send_ack, out_res_reg.ack_seq == '0 && !out_res_reg.ack_with_params, "ack fields set without an acknowledgement")
    `FTR_ASSERT_NEXT(a_take_fills_input, in_take, in_valid_reg, "accepted event not held in the input register")

endmodule
